### hw/rtl/prf_pkg.sv
// ---------------------------------------------------------------------------
// prf_pkg
// Request codes, status codes and the response record shared by the
// packet ring FIFO modules.
// ---------------------------------------------------------------------------
package prf_pkg;

	localparam int LEN_W     = 11;
	localparam int BYTE_W    = 8;
	localparam int CNT_OUT_W = 3;

	typedef enum logic [1:0] {
		REQ_RX        = 2'd0,
		REQ_POP_BEGIN = 2'd1,
		REQ_POP_NEXT  = 2'd2,
		REQ_RESET     = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_DROPPED = 3'd2,
		ST_TRUNC   = 3'd3,
		ST_NO_POP  = 3'd4
	} status_t;

	// Response of one request as it moves from the ring state to the output.
	typedef struct packed {
		status_t                status;
		logic [LEN_W-1:0]       pop_length;
		logic                   data_last;
		logic                   byte_rd;    // data byte comes from the store
		logic                   pop_begin;  // response still needs the slot length
		logic [CNT_OUT_W-1:0]   packet_count;
	} rsp_info_t;

endpackage

### hw/rtl/packet_ring_fifo_unit.sv
// ---------------------------------------------------------------------------
// packet_ring_fifo_unit
// Ring of packet slots fed byte by byte, read back packet by packet.
// ---------------------------------------------------------------------------
// Usage: one request channel (req_valid/req_ready) carries receive byte,
// pop begin, pop next byte and ring reset requests; one response channel
// (rsp_valid/rsp_ready) returns exactly one response per request, in order.
// Response path: a request and its synchronous store read enter the read
// stage at the accept edge; the output register loads from that stage when
// it advances, which needs the output register free or being taken.
// Throughput: receive, pop next and ring reset requests go at one per cycle
// while responses are taken; a pop begin holds the next request until the
// slot length read from the length memory has updated the pop state.
// Stall: a stalled receiver holds the response register; one more request
// still goes into the read stage, then req_ready drops until the response
// is taken.
// Reset: arst_n empties the ring and clears the pop and receive state; the
// byte and length memories are not cleared, and a pop only reads entries
// that a committed packet wrote.
// ---------------------------------------------------------------------------
module packet_ring_fifo_unit
	import prf_pkg::*;
#(
	parameter int SLOTS      = 4,
	parameter int SLOT_BYTES = 1536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [1:0]           req_type,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic                 rx_last,
	input  logic                 rx_bad,
	input  logic [LEN_W-1:0]     max_len,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [2:0]           status,
	output logic [LEN_W-1:0]     pop_length,
	output logic [BYTE_W-1:0]    data_byte,
	output logic                 data_last,
	output logic [CNT_OUT_W-1:0] packet_count
);

	localparam int SW = $clog2(SLOTS);
	localparam int OW = $clog2(SLOT_BYTES + 1);

	logic              accept;
	logic              s1_adv;
	logic              pb_done;
	rsp_info_t         acc_info;
	rsp_info_t         pb_info;
	rsp_info_t         fin_info;

	logic              s1_valid_s1;
	rsp_info_t         info_s1;
	logic [LEN_W-1:0]  max_len_s1;

	logic              rsp_valid_q;
	status_t           status_q;
	logic [LEN_W-1:0]  pop_length_q;
	logic [BYTE_W-1:0] data_byte_q;
	logic              data_last_q;
	logic [CNT_OUT_W-1:0] packet_count_q;

	logic              byte_we;
	logic [SW-1:0]     byte_wslot;
	logic [OW-1:0]     byte_woff;
	logic              byte_re;
	logic [SW-1:0]     byte_rslot;
	logic [LEN_W-1:0]  byte_roff;
	logic [BYTE_W-1:0] byte_rdata;
	logic              len_we;
	logic [SW-1:0]     len_wslot;
	logic [OW-1:0]     len_wdata;
	logic              len_re;
	logic [SW-1:0]     len_rslot;
	logic [OW-1:0]     len_rdata;

	assign s1_adv    = s1_valid_s1 && (!rsp_valid_q || rsp_ready);
	// hold requests while a pop begin waits for its slot length
	assign req_ready = !s1_valid_s1 || (s1_adv && !info_s1.pop_begin);
	assign accept    = req_valid && req_ready;
	assign pb_done   = s1_adv && info_s1.pop_begin;
	assign fin_info  = info_s1.pop_begin ? pb_info : info_s1;

	prf_ctrl #(
		.SLOTS      (SLOTS),
		.SLOT_BYTES (SLOT_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req_type   (req_type),
		.rx_last    (rx_last),
		.rx_bad     (rx_bad),
		.pb_done    (pb_done),
		.pb_max_len (max_len_s1),
		.len_rdata  (len_rdata),
		.acc_info   (acc_info),
		.pb_info    (pb_info),
		.byte_we    (byte_we),
		.byte_wslot (byte_wslot),
		.byte_woff  (byte_woff),
		.byte_re    (byte_re),
		.byte_rslot (byte_rslot),
		.byte_roff  (byte_roff),
		.len_we     (len_we),
		.len_wslot  (len_wslot),
		.len_wdata  (len_wdata),
		.len_re     (len_re),
		.len_rslot  (len_rslot)
	);

	prf_store #(
		.SLOTS      (SLOTS),
		.SLOT_BYTES (SLOT_BYTES)
	) u_store (
		.clk        (clk),
		.byte_we    (byte_we),
		.byte_wslot (byte_wslot),
		.byte_woff  (byte_woff),
		.byte_wdata (rx_byte),
		.byte_re    (byte_re),
		.byte_rslot (byte_rslot),
		.byte_roff  (byte_roff),
		.byte_rdata (byte_rdata),
		.len_we     (len_we),
		.len_wslot  (len_wslot),
		.len_wdata  (len_wdata),
		.len_re     (len_re),
		.len_rslot  (len_rslot),
		.len_rdata  (len_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1    <= acc_info;
			max_len_s1 <= max_len;
		end
		if (s1_adv) begin
			status_q       <= fin_info.status;
			pop_length_q   <= fin_info.pop_length;
			data_byte_q    <= fin_info.byte_rd ? byte_rdata : '0;
			data_last_q    <= fin_info.data_last;
			packet_count_q <= fin_info.packet_count;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign pop_length   = pop_length_q;
	assign data_byte    = data_byte_q;
	assign data_last    = data_last_q;
	assign packet_count = packet_count_q;

	a_pb_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && info_s1.pop_begin) |-> !accept)
		else $error("request taken while pop begin is pending");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !s1_adv) |=> s1_valid_s1 && $stable(info_s1))
		else $error("read stage lost its request under stall");

	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && data_last_q) |-> (status_q == ST_OK && pop_length_q != '0))
		else $error("final byte with bad status or zero length");

endmodule

### hw/rtl/prf_store.sv
// ---------------------------------------------------------------------------
// prf_store
// Packet byte store and slot length store, both synchronous memories with
// one write port and one registered read port.
// ---------------------------------------------------------------------------
module prf_store
	import prf_pkg::*;
#(
	parameter int SLOTS      = 4,
	parameter int SLOT_BYTES = 1536
) (
	input  logic                          clk,
	input  logic                          byte_we,
	input  logic [$clog2(SLOTS)-1:0]      byte_wslot,
	input  logic [$clog2(SLOT_BYTES+1)-1:0] byte_woff,
	input  logic [BYTE_W-1:0]             byte_wdata,
	input  logic                          byte_re,
	input  logic [$clog2(SLOTS)-1:0]      byte_rslot,
	input  logic [LEN_W-1:0]              byte_roff,
	output logic [BYTE_W-1:0]             byte_rdata,
	input  logic                          len_we,
	input  logic [$clog2(SLOTS)-1:0]      len_wslot,
	input  logic [$clog2(SLOT_BYTES+1)-1:0] len_wdata,
	input  logic                          len_re,
	input  logic [$clog2(SLOTS)-1:0]      len_rslot,
	output logic [$clog2(SLOT_BYTES+1)-1:0] len_rdata
);

	localparam int DEPTH = SLOTS * SLOT_BYTES;
	localparam int AW    = $clog2(DEPTH);
	localparam int OW    = $clog2(SLOT_BYTES + 1);

	logic [BYTE_W-1:0] byte_mem [DEPTH];
	logic [OW-1:0]     len_mem  [SLOTS];

	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;

	// slot base is a multiply by a constant
	assign waddr = AW'(AW'(byte_wslot) * AW'(SLOT_BYTES)) + AW'(byte_woff);
	assign raddr = AW'(AW'(byte_rslot) * AW'(SLOT_BYTES)) + AW'(byte_roff);

	always_ff @(posedge clk) begin
		if (byte_we) begin
			byte_mem[waddr] <= byte_wdata;
		end
		if (byte_re) begin
			byte_rdata <= byte_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[len_wslot] <= len_wdata;
		end
		if (len_re) begin
			len_rdata <= len_mem[len_rslot];
		end
	end

endmodule

### hw/rtl/prf_ctrl.sv
// ---------------------------------------------------------------------------
// prf_ctrl
// Ring pointers, fill count, receive and pop state. Decides each request
// at accept time and finishes pop begin once the slot length is read.
// ---------------------------------------------------------------------------
module prf_ctrl
	import prf_pkg::*;
#(
	parameter int SLOTS      = 4,
	parameter int SLOT_BYTES = 1536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [1:0]                    req_type,
	input  logic                          rx_last,
	input  logic                          rx_bad,
	input  logic                          pb_done,
	input  logic [LEN_W-1:0]              pb_max_len,
	input  logic [$clog2(SLOT_BYTES+1)-1:0] len_rdata,
	output rsp_info_t                     acc_info,
	output rsp_info_t                     pb_info,
	output logic                          byte_we,
	output logic [$clog2(SLOTS)-1:0]      byte_wslot,
	output logic [$clog2(SLOT_BYTES+1)-1:0] byte_woff,
	output logic                          byte_re,
	output logic [$clog2(SLOTS)-1:0]      byte_rslot,
	output logic [LEN_W-1:0]              byte_roff,
	output logic                          len_we,
	output logic [$clog2(SLOTS)-1:0]      len_wslot,
	output logic [$clog2(SLOT_BYTES+1)-1:0] len_wdata,
	output logic                          len_re,
	output logic [$clog2(SLOTS)-1:0]      len_rslot
);

	localparam int SW   = $clog2(SLOTS);
	localparam int CW   = $clog2(SLOTS + 1);
	localparam int OW   = $clog2(SLOT_BYTES + 1);
	localparam int CMPW = (OW > LEN_W) ? OW : LEN_W;

	logic [SW-1:0]    wr_slot_q, wr_slot_d;
	logic [SW-1:0]    rd_slot_q, rd_slot_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [OW-1:0]    wr_off_q, wr_off_d;
	logic             disc_q, disc_d;
	logic [LEN_W-1:0] rd_off_q, rd_off_d;
	logic [LEN_W-1:0] rd_lim_q, rd_lim_d;
	logic             pop_q, pop_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q <= '0;
			rd_slot_q <= '0;
			cnt_q     <= '0;
			wr_off_q  <= '0;
			disc_q    <= 1'b0;
			rd_off_q  <= '0;
			rd_lim_q  <= '0;
			pop_q     <= 1'b0;
		end else begin
			wr_slot_q <= wr_slot_d;
			rd_slot_q <= rd_slot_d;
			cnt_q     <= cnt_d;
			wr_off_q  <= wr_off_d;
			disc_q    <= disc_d;
			rd_off_q  <= rd_off_d;
			rd_lim_q  <= rd_lim_d;
			pop_q     <= pop_d;
		end
	end

	logic [SW-1:0]    rd_slot_inc;
	logic [SW-1:0]    wr_slot_inc;
	logic [OW-1:0]    wr_off_new;
	logic [LEN_W-1:0] rd_off_inc;
	logic [LEN_W-1:0] pb_len;
	logic             full;

	assign rd_slot_inc = (rd_slot_q == SW'(SLOTS - 1)) ? '0 : SW'(rd_slot_q + 1'b1);
	assign wr_slot_inc = (wr_slot_q == SW'(SLOTS - 1)) ? '0 : SW'(wr_slot_q + 1'b1);
	assign rd_off_inc  = LEN_W'(rd_off_q + 1'b1);
	assign full        = (cnt_q >= CW'(SLOTS));

	// clip stored length to the caller buffer
	assign pb_len = (CMPW'(len_rdata) > CMPW'(pb_max_len)) ? pb_max_len
		: LEN_W'(len_rdata);

	assign byte_wslot = wr_slot_q;
	assign byte_woff  = wr_off_q;
	assign byte_rslot = rd_slot_q;
	assign byte_roff  = rd_off_q;
	assign len_wslot  = wr_slot_q;
	assign len_rslot  = rd_slot_q;

	always_comb begin
		wr_slot_d  = wr_slot_q;
		rd_slot_d  = rd_slot_q;
		cnt_d      = cnt_q;
		wr_off_d   = wr_off_q;
		disc_d     = disc_q;
		rd_off_d   = rd_off_q;
		rd_lim_d   = rd_lim_q;
		pop_d      = pop_q;
		byte_we    = 1'b0;
		byte_re    = 1'b0;
		len_we     = 1'b0;
		len_re     = 1'b0;
		len_wdata  = wr_off_q;
		wr_off_new = wr_off_q;
		acc_info   = '{status: ST_OK, pop_length: '0, data_last: 1'b0,
			byte_rd: 1'b0, pop_begin: 1'b0, packet_count: '0};
		pb_info    = acc_info;

		if (accept) begin
			unique case (req_t'(req_type))
				REQ_RX: begin
					if (disc_q || (wr_off_q == '0 && full)) begin
						// drop the whole packet up to its last byte
						acc_info.status = ST_DROPPED;
						disc_d = !rx_last;
					end else begin
						if (wr_off_q < OW'(SLOT_BYTES)) begin
							byte_we    = 1'b1;
							wr_off_new = OW'(wr_off_q + 1'b1);
						end else begin
							acc_info.status = ST_TRUNC;
						end
						wr_off_d = wr_off_new;
						if (rx_last) begin
							wr_off_d = '0;
							if (!rx_bad && wr_off_new != '0 && !full) begin
								len_we    = 1'b1;
								len_wdata = wr_off_new;
								wr_slot_d = wr_slot_inc;
								cnt_d     = CW'(cnt_q + 1'b1);
							end
						end
					end
				end
				REQ_POP_BEGIN: begin
					// finished once the slot length is back
					acc_info.pop_begin = 1'b1;
					len_re = 1'b1;
				end
				REQ_POP_NEXT: begin
					if (!pop_q || rd_off_q >= rd_lim_q || 32'(rd_off_q) >= SLOT_BYTES) begin
						acc_info.status = ST_NO_POP;
					end else begin
						byte_re = 1'b1;
						acc_info.byte_rd    = 1'b1;
						acc_info.pop_length = rd_lim_q;
						rd_off_d = rd_off_inc;
						if (rd_off_inc >= rd_lim_q) begin
							acc_info.data_last = 1'b1;
							rd_slot_d = rd_slot_inc;
							pop_d     = 1'b0;
							if (cnt_q != '0) begin
								cnt_d = CW'(cnt_q - 1'b1);
							end
						end
					end
				end
				REQ_RESET: begin
					wr_slot_d = '0;
					rd_slot_d = '0;
					cnt_d     = '0;
					wr_off_d  = '0;
					disc_d    = 1'b0;
					rd_off_d  = '0;
					rd_lim_d  = '0;
					pop_d     = 1'b0;
				end
				default: begin
				end
			endcase
		end else if (pb_done) begin
			if (cnt_q == '0) begin
				pb_info.status = ST_EMPTY;
				pop_d = 1'b0;
			end else begin
				pb_info.pop_length = pb_len;
				rd_off_d = '0;
				rd_lim_d = pb_len;
				pop_d    = 1'b1;
				if (pb_len == '0) begin
					// nothing to deliver: release the tail now
					rd_slot_d = rd_slot_inc;
					cnt_d     = CW'(cnt_q - 1'b1);
					pop_d     = 1'b0;
				end
			end
		end

		acc_info.packet_count = CNT_OUT_W'(cnt_d);
		pb_info.packet_count  = CNT_OUT_W'(cnt_d);
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(SLOTS))
		else $error("packet count above ring size");

	a_pop_has_packet: assert property (@(posedge clk) disable iff (!arst_n)
		pop_q |-> (cnt_q != '0 && rd_off_q < rd_lim_q))
		else $error("active pop without a readable tail packet");

	a_disc_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		disc_q |-> (wr_off_q == '0))
		else $error("discard while a packet is being stored");

endmodule

### bench/tb_packet_ring_fifo_unit.sv
// ---------------------------------------------------------------------------
// tb_packet_ring_fifo_unit
// Self-checking bench for the packet ring FIFO. A driver feeds receive, pop
// and ring reset requests from a backlog queue with random gaps. A
// receiver stalls at random and at two set points, unless the backlog runs
// low, holds off long enough to back the block up. A monitor predicts each
// accepted request and checks every response field against it.
// ---------------------------------------------------------------------------
module tb_packet_ring_fifo_unit;
	import prf_pkg::*;

	localparam int NUM_SLOTS    = 4;
	localparam int SLOT_SIZE    = 1536;
	localparam int RANDOM_ITEMS = 1050;
	localparam int QUIET_ITEMS  = 120;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_LEN     = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		req_t              kind;
		logic [BYTE_W-1:0] rx_b;
		logic              last;
		logic              bad;
		logic [LEN_W-1:0]  mlen;
	} ring_req_t;

	typedef struct {
		status_t              st;
		logic [LEN_W-1:0]     plen;
		logic [BYTE_W-1:0]    dbyte;
		logic                 dlast;
		logic [CNT_OUT_W-1:0] count;
	} ring_answer_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	logic [1:0]           req_type = REQ_RX;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 rx_last = 1'b0;
	logic                 rx_bad = 1'b0;
	logic [LEN_W-1:0]     max_len = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	logic [2:0]           status;
	logic [LEN_W-1:0]     pop_length;
	logic [BYTE_W-1:0]    data_byte;
	logic                 data_last;
	logic [CNT_OUT_W-1:0] packet_count;

	ring_req_t    req_backlog[$];
	ring_answer_t due_answers[$];
	logic         quiet = 1'b0;
	int           fails = 0;

	// shadow of the ring
	logic [BYTE_W-1:0] stash [NUM_SLOTS*SLOT_SIZE];
	int unsigned       stash_len [NUM_SLOTS];
	int unsigned       wr_slot = 0, rd_slot = 0, held = 0;
	int unsigned       wr_ofs = 0, rd_ofs = 0, rd_lim = 0;
	bit                dropping = 1'b0, popping = 1'b0;

	packet_ring_fifo_unit #(
		.SLOTS      (NUM_SLOTS),
		.SLOT_BYTES (SLOT_SIZE)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.rx_byte      (rx_byte),
		.rx_last      (rx_last),
		.rx_bad       (rx_bad),
		.max_len      (max_len),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.status       (status),
		.pop_length   (pop_length),
		.data_byte    (data_byte),
		.data_last    (data_last),
		.packet_count (packet_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void retire_tail();
		rd_slot = (rd_slot + 1) % NUM_SLOTS;
		if (held > 0)
			held--;
		popping = 1'b0;
	endfunction

	function automatic ring_answer_t ring_answer(ring_req_t rq);
		ring_answer_t a;
		int unsigned  len;
		a = '{st: ST_OK, plen: '0, dbyte: '0, dlast: 1'b0, count: '0};
		case (rq.kind)
			REQ_RX: begin
				if (!dropping && wr_ofs == 0 && held >= NUM_SLOTS)
					dropping = 1'b1;
				if (dropping) begin
					if (rq.last)
						dropping = 1'b0;
					a.st = ST_DROPPED;
				end else begin
					if (wr_ofs < SLOT_SIZE) begin
						stash[wr_slot*SLOT_SIZE + wr_ofs] = rq.rx_b;
						wr_ofs++;
					end else begin
						a.st = ST_TRUNC;
					end
					if (rq.last) begin
						// commit unless flagged bad, empty or the ring is full
						if (!rq.bad && wr_ofs > 0 && held < NUM_SLOTS) begin
							stash_len[wr_slot] = wr_ofs;
							wr_slot = (wr_slot + 1) % NUM_SLOTS;
							held++;
						end
						wr_ofs = 0;
					end
				end
			end
			REQ_POP_BEGIN: begin
				if (held == 0) begin
					a.st = ST_EMPTY;
					popping = 1'b0;
				end else begin
					len = stash_len[rd_slot];
					if (len > rq.mlen)
						len = rq.mlen;
					a.plen = LEN_W'(len);
					rd_ofs = 0;
					rd_lim = len;
					popping = 1'b1;
					if (len == 0)
						retire_tail();
				end
			end
			REQ_POP_NEXT: begin
				if (!popping || rd_ofs >= rd_lim || rd_ofs >= SLOT_SIZE) begin
					a.st = ST_NO_POP;
				end else begin
					a.dbyte = stash[rd_slot*SLOT_SIZE + rd_ofs];
					rd_ofs++;
					a.plen = LEN_W'(rd_lim);
					if (rd_ofs >= rd_lim) begin
						a.dlast = 1'b1;
						retire_tail();
					end
				end
			end
			default: begin
				wr_slot = 0;
				rd_slot = 0;
				held = 0;
				wr_ofs = 0;
				dropping = 1'b0;
				rd_ofs = 0;
				rd_lim = 0;
				popping = 1'b0;
			end
		endcase
		a.count = CNT_OUT_W'(held);
		return a;
	endfunction

	task automatic push_item(req_t kind, logic [BYTE_W-1:0] b, logic l, logic bd,
			logic [LEN_W-1:0] m);
		ring_req_t rq;
		rq.kind = kind;
		rq.rx_b = b;
		rq.last = l;
		rq.bad = bd;
		rq.mlen = m;
		req_backlog.push_back(rq);
	endtask

	task automatic push_rx(logic [BYTE_W-1:0] b, logic l, logic bd);
		push_item(REQ_RX, b, l, bd, LEN_W'($urandom_range(0, 2047)));
	endtask

	task automatic push_pop(logic [LEN_W-1:0] m);
		push_item(REQ_POP_BEGIN, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), m);
	endtask

	task automatic push_next();
		push_item(REQ_POP_NEXT, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), LEN_W'($urandom_range(0, 2047)));
	endtask

	task automatic push_clear();
		push_item(REQ_RESET, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), LEN_W'($urandom_range(0, 2047)));
	endtask

	task automatic push_pkt(int len, bit bad);
		for (int i = 0; i < len; i++)
			push_rx(BYTE_W'($urandom_range(0, 255)), i == len - 1,
				1'((i == len - 1) ? bad : $urandom_range(0, 1)));
	endtask

	task automatic flag_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			fails++;
		end
	endtask

	// driver
	ring_req_t   cur;
	int          gap_left = 0, gap_odds = 0;
	int unsigned drv_cycles = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			gap_left = 0;
		end else begin
			drv_cycles++;
			if (drv_cycles % 128 == 0)
				gap_odds = $urandom_range(0, 4);
			quiet <= (req_backlog.size() < QUIET_ITEMS);
			if (!req_valid || req_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					cur = req_backlog.pop_front();
					req_valid <= 1'b1;
					req_type <= cur.kind;
					rx_byte <= cur.rx_b;
					rx_last <= cur.last;
					rx_bad <= cur.bad;
					max_len <= cur.mlen;
					if (!quiet && gap_odds != 0 && $urandom_range(0, 15) < gap_odds)
						gap_left = $urandom_range(1, 12);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response receiver
	int          hold_left = 0, stall_left = 0, stall_odds = 0;
	int unsigned rcv_cycles = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			rcv_cycles++;
			if (rcv_cycles % 128 == 0)
				stall_odds = $urandom_range(0, 4);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (!quiet && (rcv_cycles == HOLD_AT || rcv_cycles == 3*HOLD_AT)) begin
				// long hold-off: let the block fill and stall its requests
				hold_left = HOLD_LEN;
				rsp_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (!quiet && stall_odds != 0 && $urandom_range(0, 15) < stall_odds) begin
				stall_left = $urandom_range(0, 11);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// monitor and watchdog
	ring_answer_t want;
	ring_req_t    seen;
	int           idle_run = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			// check before predicting so a stray response cannot match a fresh request
			if (rsp_valid && rsp_ready) begin
				if (due_answers.size() == 0) begin
					$display("%0t: response with nothing expected, status %0d", $time,
						status);
					fails++;
				end else begin
					want = due_answers.pop_front();
					flag_field("status", int'(want.st), int'(status));
					flag_field("pop_length", int'(want.plen), int'(pop_length));
					flag_field("data_byte", int'(want.dbyte), int'(data_byte));
					flag_field("data_last", int'(want.dlast), int'(data_last));
					flag_field("packet_count", int'(want.count), int'(packet_count));
				end
			end
			if (req_valid && req_ready) begin
				seen.kind = req_t'(req_type);
				seen.rx_b = rx_byte;
				seen.last = rx_last;
				seen.bad = rx_bad;
				seen.mlen = max_len;
				due_answers.push_back(ring_answer(seen));
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_run = 0;
			else
				idle_run++;
			if (idle_run >= STALL_LIMIT) begin
				$display("%0t: no request or response moved for %0d cycles", $time,
					idle_run);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// stimulus and end of run
	int               mark, made, r, len, n, pkt_odds;
	logic [LEN_W-1:0] m;

	initial begin
		// directed: empty ring, zero and restarted pops, bad packets, full ring, reset
		push_next();
		push_pop(11'h7FF);
		push_rx(8'h00, 1'b1, 1'b0);
		push_rx(8'hFF, 1'b0, 1'b1);
		push_rx(8'hA5, 1'b1, 1'b0);
		push_rx(8'h3C, 1'b0, 1'b0);
		push_rx(8'hC3, 1'b1, 1'b1);
		push_pop(11'd0);
		push_pop(11'h7FF);
		push_pop(11'd1);
		push_next();
		push_next();
		for (int i = 0; i < NUM_SLOTS; i++)
			push_rx(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0);
		push_rx(8'h5A, 1'b0, 1'b0);
		push_rx(8'h96, 1'b1, 1'b0);
		push_pop(11'h400);
		push_next();
		push_rx(8'h81, 1'b1, 1'b0);
		push_next();
		push_rx(8'h42, 1'b0, 1'b0);
		push_clear();
		push_pop(11'd5);

		made = 0;
		pkt_odds = 50;
		while (made < RANDOM_ITEMS) begin
			if ($urandom_range(0, 39) == 0)
				pkt_odds = $urandom_range(25, 70);
			mark = req_backlog.size();
			r = $urandom_range(0, 99);
			if (r < pkt_odds) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
					: $urandom_range(1, 12);
				push_pkt(len, $urandom_range(0, 6) == 0);
			end else if (r < 92) begin
				case ($urandom_range(0, 3))
					0: m = LEN_W'($urandom_range(0, 12));
					3: m = LEN_W'($urandom_range(SLOT_SIZE + 1, 2047));
					default: m = LEN_W'($urandom_range(12, SLOT_SIZE));
				endcase
				push_pop(m);
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16)
					: $urandom_range(1, 12);
				for (int i = 0; i < n; i++) begin
					push_next();
					if ($urandom_range(0, 24) == 0)
						push_pop(LEN_W'($urandom_range(0, 2047)));
				end
			end else if (r < 99) begin
				push_item(req_t'($urandom_range(0, 2)), BYTE_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					LEN_W'($urandom_range(0, 2047)));
			end else begin
				push_clear();
			end
			made += req_backlog.size() - mark;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_backlog.size() != 0 || req_valid)
			@(negedge clk);
		while (due_answers.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
